// File: rtl/pcm_pkg.sv
`default_nettype none
package pcm_pkg;

  localparam int NUM_SLOTS_DEF    = 4;
  localparam int NUM_TIMEOUT_REGS = 4;
  localparam int COMP_W           = 16;
  localparam int NUM_COMP         = 6;
  localparam int CMD_W            = COMP_W * NUM_COMP;
  localparam int AGE_W            = 17;
  localparam int TMO_W            = 16;
  localparam int SRC_W            = 2;
  localparam int SLOT_W           = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int OP_W             = 2;
  localparam int IN_DATA_W        = 104;
  localparam int OUT_DATA_W       = 104;

  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(4);
  localparam logic [AGE_W-1:0]  AGE_MAX = {AGE_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT     = 2'd0,
    OP_TICK       = 2'd1,
    OP_FORCE_STOP = 2'd2,
    OP_CLEAR_STOP = 2'd3
  } op_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 submit;
    logic                 tick;
    logic [SRC_W-1:0]     src;
    logic [CMD_W-1:0]     cmd;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [TMO_W-1:0]     cfg_data;
  } cell_ctl_t;

  // priority pick handed from lower- to higher-priority cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [CMD_W-1:0]  cmd;
  } pick_t;

endpackage
`default_nettype wire

// File: rtl/pcm_slot_cell.sv
`default_nettype none
module pcm_slot_cell
  import pcm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire pick_t     pick_i,
  output pick_t          pick_o
);

  localparam bit HAS_TMO = (IDX < NUM_TIMEOUT_REGS);

  logic [CMD_W-1:0] cmd_r;
  logic             active_r;
  logic [AGE_W-1:0] age_r;
  logic [TMO_W-1:0] tmo_r;
  logic             sel;
  logic             cfg_sel;
  logic             live;

  assign sel     = HAS_TMO && ctl.submit && (ctl.src == SRC_W'(IDX));
  assign cfg_sel = HAS_TMO && ctl.cfg_we && (ctl.cfg_idx == CFG_IDX_W'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      age_r    <= '0;
      tmo_r    <= '0;
    end else begin
      if (sel) begin
        active_r <= 1'b1;
        age_r    <= '0;
      end else if (ctl.tick && age_r != AGE_MAX) begin
        age_r <= age_r + AGE_W'(1);
      end
      if (cfg_sel) begin
        tmo_r <= ctl.cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      cmd_r <= ctl.cmd;
    end
  end

  // zero timeout never expires
  assign live = active_r && ((tmo_r == '0) || (age_r <= {1'b0, tmo_r}));

  always_comb begin
    if (live) begin
      pick_o.found = 1'b1;
      pick_o.slot  = SLOT_W'(IDX);
      pick_o.cmd   = cmd_r;
    end else begin
      pick_o = pick_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/priority_command_mux_with_timeout_core.sv
`default_nettype none
// Priority velocity command multiplexer with per-slot timeout. A row of slot
// cells, slot 0 first and highest priority, each holds one six-component Q5.10
// command, its active flag, a saturating 17-bit millisecond age and its timeout
// register. Every input item (submit, tick, force stop, clear stop) returns one
// result item: the command of the first active, unexpired slot, or zeros with
// chosen_slot 4 while stopped or when nothing qualifies. An item updates the
// cells on the edge it is accepted; the pick then ripples through the cell row
// and lands in the output register once that register is free to load. The
// block takes no new item until the result of the last one is loaded, so a
// stalled result holds off further items.
module priority_command_mux_with_timeout_core
  import pcm_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // source, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  wire logic [OP_W-1:0]       in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z,
  // chosen_slot, stopped, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [TMO_W-1:0]      cfg_wdata
);

  localparam int PAD_W = OUT_DATA_W - CMD_W - SLOT_W - 1;

  logic                  accept;
  op_t                   op;
  cell_ctl_t             ctl;
  pick_t                 chain [NUM_SLOTS+1];
  logic                  stop_r;
  logic                  pend_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  load;
  logic [SLOT_W-1:0]     chosen;
  logic [CMD_W-1:0]      eff_cmd;

  // one item in flight at a time
  assign in_tready = !pend_r;
  assign accept    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);

  assign ctl.submit   = accept && (op == OP_SUBMIT);
  assign ctl.tick     = accept && (op == OP_TICK);
  assign ctl.src      = in_tdata[SRC_W-1:0];
  assign ctl.cmd      = in_tdata[SRC_W +: CMD_W];
  assign ctl.cfg_we   = cfg_we;
  assign ctl.cfg_idx  = cfg_index;
  assign ctl.cfg_data = cfg_wdata;

  // lowest-priority end of the row sees nothing found
  assign chain[NUM_SLOTS] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    pcm_slot_cell #(
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .pick_i (chain[i+1]),
      .pick_o (chain[i])
    );
  end

  // stop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b0;
    end else if (accept) begin
      case (op)
        OP_FORCE_STOP: stop_r <= 1'b1;
        OP_CLEAR_STOP: stop_r <= 1'b0;
        default:       stop_r <= stop_r;
      endcase
    end
  end

  // stop or no qualifying slot gives zero command
  always_comb begin
    if (!stop_r && chain[0].found) begin
      chosen  = chain[0].slot;
      eff_cmd = chain[0].cmd;
    end else begin
      chosen  = NO_SLOT;
      eff_cmd = '0;
    end
  end

  assign load = pend_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pend_r <= 1'b1;
      end else if (load) begin
        pend_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {{PAD_W{1'b0}}, stop_r, chosen, eff_cmd};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pcm_pkg::*;

  // run limits and pacing
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 8;

  // q5.10 extremes
  localparam logic [COMP_W-1:0] Q_MIN = 16'h8000;
  localparam logic [COMP_W-1:0] Q_MAX = 16'h7FFF;

  // six velocity components, lin_x in the lowest bits
  typedef logic [NUM_COMP-1:0][COMP_W-1:0] twist_t;

  typedef struct packed {
    twist_t            vel;
    logic [SLOT_W-1:0] slot;
    logic              stopped;
  } mux_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  // source, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // opcode
  logic [OP_W-1:0]       in_tuser = OP_TICK;
  logic                  in_tvalid = 1'b0;
  wire logic             in_tready;
  // out_lin_x .. out_ang_z, chosen_slot, stopped, zero pad
  wire logic [OUT_DATA_W-1:0] out_tdata;
  wire logic             out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TMO_W-1:0]      cfg_wdata = '0;

  // pacing knobs, percent of cycles spent idle on each side
  int tx_idle_pct = 22;
  int rx_idle_pct = 22;
  // long receiver hold-off, requested by a test and counted by the receiver
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int fail_count = 0;
  int cycle_count = 0;

  // predictor state, mirrors the slot row of the block
  twist_t           slot_twist[NUM_SLOTS_DEF];
  logic             slot_on[NUM_SLOTS_DEF];
  logic [AGE_W-1:0] slot_age[NUM_SLOTS_DEF];
  logic             stop_q;
  logic [TMO_W-1:0] timeout_q[NUM_TIMEOUT_REGS];

  // expected effective commands, oldest first
  mux_out_t pending_cmds[$];

  priority_command_mux_with_timeout_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one item to the mirrored slots and work out the effective command
  function automatic mux_out_t predict_mux(input op_t op, input logic [SRC_W-1:0] src,
                                           input twist_t vel);
    mux_out_t res;
    logic     found;
    found = 1'b0;
    case (op)
      OP_SUBMIT: begin
        // the 2-bit source always lands inside the four slots
        slot_twist[src] = vel;
        slot_on[src]    = 1'b1;
        slot_age[src]   = '0;
      end
      OP_TICK: begin
        // every slot ages, active or not, and the age sticks at its maximum
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
          if (slot_age[i] != AGE_MAX) begin
            slot_age[i] = slot_age[i] + 1'b1;
          end
        end
      end
      OP_FORCE_STOP: stop_q = 1'b1;
      default: stop_q = 1'b0;
    endcase
    res.vel     = '0;
    res.slot    = NO_SLOT;
    res.stopped = stop_q;
    if (!stop_q) begin
      // first active slot that is either timeless or not yet past its timeout
      for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
        if (!found && slot_on[i] && (timeout_q[i] == '0 || slot_age[i] <= timeout_q[i])) begin
          found    = 1'b1;
          res.vel  = slot_twist[i];
          res.slot = SLOT_W'(i);
        end
      end
    end
    return res;
  endfunction

  // six components, each biased towards the q5.10 extremes
  function automatic twist_t rand_twist();
    twist_t v;
    for (int k = 0; k < NUM_COMP; k++) begin
      case ($urandom_range(7))
        0: v[k] = Q_MIN;
        1: v[k] = Q_MAX;
        2: v[k] = '0;
        3: v[k] = '1;
        default: v[k] = COMP_W'($urandom);
      endcase
    end
    return v;
  endfunction

  // mostly short timeouts so that ticks really expire slots
  function automatic logic [TMO_W-1:0] rand_timeout();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return TMO_W'($urandom);
      default: return TMO_W'($urandom_range(8, 1));
    endcase
  endfunction

  // predictor and checker, both on the rising edge
  always @(posedge clk) begin
    mux_out_t got;
    mux_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
        slot_twist[i] = '0;
        slot_on[i]    = 1'b0;
        slot_age[i]   = '0;
      end
      for (int i = 0; i < NUM_TIMEOUT_REGS; i++) begin
        timeout_q[i] = '0;
      end
      stop_q = 1'b0;
      pending_cmds.delete();
    end else begin
      // indices past the timeout registers are dropped by the block
      if (cfg_we && int'(cfg_index) < NUM_TIMEOUT_REGS) begin
        timeout_q[cfg_index[1:0]] = cfg_wdata;
      end
      // check first: a result never belongs to an item accepted on this edge
      if (out_tvalid && out_tready) begin
        got.vel     = out_tdata[CMD_W-1:0];
        got.slot    = out_tdata[CMD_W +: SLOT_W];
        got.stopped = out_tdata[CMD_W + SLOT_W];
        if (pending_cmds.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected result item: vel %h slot %0d stopped %0b",
                     got.vel, got.slot, got.stopped);
          end
        end else begin
          want = pending_cmds.pop_front();
          if (got.vel !== want.vel || got.slot !== want.slot ||
              got.stopped !== want.stopped) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("result mismatch: expected vel %h slot %0d stopped %0b",
                       want.vel, want.slot, want.stopped);
              $display("                 actual   vel %h slot %0d stopped %0b",
                       got.vel, got.slot, got.stopped);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_cmds.push_back(predict_mux(op_t'(in_tuser), in_tdata[SRC_W-1:0],
                                           in_tdata[SRC_W +: CMD_W]));
      end
    end
  end

  // receiver: random stalls, plus the long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // offer one item, entered and left at a falling edge; valid stays high
  // on return so back-to-back items need no extra assignment
  task automatic send_cmd(input op_t op, input logic [SRC_W-1:0] src, input twist_t vel);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= IN_DATA_W'({vel, src});
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_tready);
    @(negedge clk);
  endtask

  // stop offering and wait until every expected item has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write all four timeouts, optionally also the unused indices above them
  task automatic load_timeouts(input logic [TMO_W-1:0] t0, input logic [TMO_W-1:0] t1,
                               input logic [TMO_W-1:0] t2, input logic [TMO_W-1:0] t3,
                               input bit poke_unused);
    logic [TMO_W-1:0] vals[NUM_TIMEOUT_REGS];
    vals = '{t0, t1, t2, t3};
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      if (i < NUM_TIMEOUT_REGS || poke_unused) begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_wdata <= (i < NUM_TIMEOUT_REGS) ? vals[i % NUM_TIMEOUT_REGS] : TMO_W'($urandom);
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // fresh out of reset: no slot active, output forced to zero
  task automatic test_reset_state();
    send_cmd(OP_TICK, SRC_W'(0), '0);
    send_cmd(OP_CLEAR_STOP, SRC_W'(3), '1);
    settle();
  endtask

  // hand-picked items: extremes, every operation, expiry boundary, stop handling
  task automatic test_directed();
    // slot 0 never expires, slot 1 after 2 ms, slot 2 practically never, slot 3 after 1 ms
    load_timeouts(16'd0, 16'd2, 16'hFFFF, 16'd1, 1'b1);
    send_cmd(OP_SUBMIT, SRC_W'(3), {NUM_COMP{Q_MIN}});
    send_cmd(OP_TICK, SRC_W'(1), rand_twist());
    // age above timeout drops slot 3
    send_cmd(OP_TICK, SRC_W'(2), rand_twist());
    send_cmd(OP_SUBMIT, SRC_W'(2), {NUM_COMP{Q_MAX}});
    send_cmd(OP_SUBMIT, SRC_W'(1), {16'h0001, Q_MIN, 16'hFFFF, 16'h0000, Q_MAX, 16'h5555});
    send_cmd(OP_TICK, SRC_W'(0), '1);
    // age equal to timeout is still live
    send_cmd(OP_TICK, SRC_W'(3), '0);
    send_cmd(OP_TICK, SRC_W'(0), rand_twist());
    // stop wins over everything, submit while stopped still stores
    send_cmd(OP_FORCE_STOP, SRC_W'(0), rand_twist());
    send_cmd(OP_SUBMIT, SRC_W'(0), {NUM_COMP{16'hFFFF}});
    send_cmd(OP_FORCE_STOP, SRC_W'(2), '1);
    send_cmd(OP_CLEAR_STOP, SRC_W'(1), rand_twist());
    send_cmd(OP_CLEAR_STOP, SRC_W'(3), '1);
    // an all-zero command from a live slot still reports its slot
    send_cmd(OP_SUBMIT, SRC_W'(0), '0);
    send_cmd(OP_TICK, SRC_W'(0), '0);
    send_cmd(OP_TICK, SRC_W'(0), '0);
    send_cmd(OP_TICK, SRC_W'(0), '0);
    send_cmd(OP_SUBMIT, SRC_W'(1), {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    send_cmd(OP_SUBMIT, SRC_W'(3), {Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN});
    settle();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills and has to hold its input back
  task automatic test_backpressure();
    load_timeouts(TMO_W'($urandom_range(6, 1)), 16'd0, TMO_W'($urandom_range(6, 1)),
                  16'd3, 1'b0);
    tx_idle_pct = 0;
    hold_reqs++;
    for (int n = 0; n < 40; n++) begin
      send_cmd(op_t'($urandom_range(3)), SRC_W'($urandom_range(3)), rand_twist());
    end
    settle();
    tx_idle_pct = 22;
  endtask

  // random phases, each with its own timeout set; one phase runs without idling
  task automatic test_random_phases();
    int   r;
    op_t  op;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_timeouts('0, '0, '0, '0, 1'b1);
        1: load_timeouts('1, '1, '1, '1, 1'b0);
        default: load_timeouts(rand_timeout(), rand_timeout(), rand_timeout(),
                               rand_timeout(), 1'($urandom_range(1)));
      endcase
      tx_idle_pct = (p == 4) ? 0 : 22;
      rx_idle_pct = (p == 4) ? 0 : 22;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        // ticks dominate so that ages actually cross the short timeouts
        if (r < 35) begin
          op = OP_SUBMIT;
        end else if (r < 80) begin
          op = OP_TICK;
        end else if (r < 90) begin
          op = OP_FORCE_STOP;
        end else begin
          op = OP_CLEAR_STOP;
        end
        send_cmd(op, SRC_W'($urandom_range(3)), rand_twist());
      end
      settle();
    end
    tx_idle_pct = 22;
    rx_idle_pct = 22;
  endtask

  initial begin
    // synchronous reset
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_directed();
    test_backpressure();
    test_random_phases();

    // anything still expected here never arrived
    fail_count += pending_cmds.size();
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
